### src/agc_pkg.sv
package agc_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int BAND_W    = 7;
  localparam int SPAN_W    = 8;
  localparam int SUM_W     = 22;
  localparam int GAIN_W    = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // quotient bits produced by the divider, one per cycle
  localparam int DIV_STEPS = GAIN_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_MID_LEVEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SPAN = 2'd2;

  localparam logic [SAMPLE_W-1:0] MID_LEVEL_RST   = 8'd128;
  localparam logic [BAND_W-1:0]   BAND_RST        = 7'd60;
  localparam logic [SPAN_W-1:0]   TARGET_SPAN_RST = 8'd160;

  typedef struct packed {
    logic acc;    // item accepted: classify and accumulate
    logic mul1;   // cross products and span*high_count
    logic mul2;   // level difference and full numerator
    logic chk;    // range check
    logic prep1;  // scale by 251 and 500
    logic prep2;  // load divider
    logic div;    // one quotient bit
    logic fin;    // latch result, clear accumulators
  } agc_cmd_t;

  typedef struct packed {
    logic ok;
  } agc_sts_t;

endpackage

### src/agc_ctrl.sv
module agc_ctrl
  import agc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_last,
  input  agc_sts_t sts,
  output agc_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_CHK,
    ST_PREP1,
    ST_PREP2,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic                   out_valid_r;
  logic                   accept;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.acc = accept;
        if (accept && in_last) state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = ST_PREP1;
      end
      ST_PREP1: begin
        cmd.prep1 = 1'b1;
        state_nxt = sts.ok ? ST_PREP2 : ST_DONE;
      end
      ST_PREP2: begin
        cmd.prep2   = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div     = 1'b1;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= (state_r == ST_DONE);
    end
  end

  // a result strobe is never held high back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // the last item of a set starts the computation
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last) |=> busy)
    else $error("last item did not start computation");

  // ordinary items stream without stalling
  a_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last) |=> !busy)
    else $error("non-last item stalled the block");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_cnt_r <= DIV_CNT_W'(DIV_STEPS - 1)))
    else $error("divider step count overran");

endmodule

### src/agc_datapath.sv
module agc_datapath
  import agc_pkg::*;
#(
  parameter int MAX_SAMPLES = 16384
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  agc_cmd_t              cmd,
  output agc_sts_t              sts,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data,
  output logic [GAIN_W-1:0]     out_gain,
  output logic                  out_error
);

  localparam int CNT_LIM  = (MAX_SAMPLES < 32767) ? MAX_SAMPLES : 32767;
  localparam int CNT_W    = $clog2(CNT_LIM + 1);
  localparam int A_W      = SUM_W + CNT_W;
  localparam int D_W      = A_W;
  localparam int TP_W     = SPAN_W + CNT_W;
  localparam int P_W      = TP_W + CNT_W;
  localparam int CK_W     = ((P_W + 1) > (D_W + 2)) ? (P_W + 1) : (D_W + 2);
  localparam int P251_W   = P_W + 8;
  localparam int M_W      = D_W + 9;
  localparam int DV_W     = ((P251_W + 16) > (M_W + DIV_STEPS - 1)) ?
                            (P251_W + 16) : (M_W + DIV_STEPS - 1);

  logic [SAMPLE_W-1:0] mid_r;
  logic [BAND_W-1:0]   band_r;
  logic [SPAN_W-1:0]   span_r;

  logic [SUM_W-1:0]    hs_r, ls_r;
  logic [CNT_W-1:0]    hc_r, lc_r;

  logic [A_W-1:0]      a_r, b_r;
  logic [TP_W-1:0]     tp_r;
  logic [D_W-1:0]      d_r;
  logic [P_W-1:0]      p_r;
  logic                ok_r;
  logic [P251_W-1:0]   p251_r;
  logic [M_W-1:0]      m_r;
  logic [DV_W-1:0]     rem_r, msh_r;
  logic [GAIN_W-1:0]   q_r;
  logic [GAIN_W-1:0]   gain_r;
  logic                err_r;

  logic [SAMPLE_W:0]   hi_th, lo_sum;
  logic                is_hi, is_lo;
  logic [SUM_W:0]      hs_add, ls_add;
  logic                hs_take, ls_take;
  logic [A_W-1:0]      a_mul, b_mul;
  logic [TP_W-1:0]     tp_mul;
  logic [P_W-1:0]      p_mul;
  logic [CK_W-1:0]     two_p, d_ext, three_d;

  // high: sample > mid + band, low: sample + band < mid
  assign hi_th  = {1'b0, mid_r} + {2'b0, band_r};
  assign lo_sum = {1'b0, in_sample} + {2'b0, band_r};
  assign is_hi  = {1'b0, in_sample} > hi_th;
  assign is_lo  = lo_sum < {1'b0, mid_r};

  // a class is full when its count hits the limit or the sum would overflow
  assign hs_add  = {1'b0, hs_r} + {{(SUM_W - SAMPLE_W + 1){1'b0}}, in_sample};
  assign ls_add  = {1'b0, ls_r} + {{(SUM_W - SAMPLE_W + 1){1'b0}}, in_sample};
  assign hs_take = cmd.acc && is_hi && (hc_r < CNT_W'(CNT_LIM)) && !hs_add[SUM_W];
  assign ls_take = cmd.acc && !is_hi && is_lo && (lc_r < CNT_W'(CNT_LIM)) &&
                   !ls_add[SUM_W];

  assign a_mul  = hs_r * lc_r;
  assign b_mul  = ls_r * hc_r;
  assign tp_mul = span_r * hc_r;
  assign p_mul  = tp_r * lc_r;

  assign two_p   = CK_W'(p_r) << 1;
  assign d_ext   = CK_W'(d_r);
  assign three_d = d_ext + (d_ext << 1);

  assign sts.ok    = ok_r;
  assign out_gain  = gain_r;
  assign out_error = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r  <= MID_LEVEL_RST;
      band_r <= BAND_RST;
      span_r <= TARGET_SPAN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MID_LEVEL:   mid_r  <= cfg_data;
        CFG_BAND:        band_r <= cfg_data[BAND_W-1:0];
        CFG_TARGET_SPAN: span_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r <= '0;
      hc_r <= '0;
      ls_r <= '0;
      lc_r <= '0;
    end else if (cmd.fin) begin
      hs_r <= '0;
      hc_r <= '0;
      ls_r <= '0;
      lc_r <= '0;
    end else begin
      if (hs_take) begin
        hs_r <= hs_add[SUM_W-1:0];
        hc_r <= hc_r + 1'b1;
      end
      if (ls_take) begin
        ls_r <= ls_add[SUM_W-1:0];
        lc_r <= lc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      a_r  <= a_mul;
      b_r  <= b_mul;
      tp_r <= tp_mul;
    end
    if (cmd.mul2) begin
      d_r <= (a_r > b_r) ? (a_r - b_r) : '0;
      p_r <= p_mul;
    end
    if (cmd.chk) begin
      ok_r <= (hc_r != '0) && (lc_r != '0) && (d_r != '0) &&
              (two_p >= d_ext) && (two_p <= three_d);
    end
    // 251 = 256 - 4 - 1, 500 = 512 - 8 - 4
    if (cmd.prep1) begin
      p251_r <= (P251_W'(p_r) << 8) - (P251_W'(p_r) << 2) - P251_W'(p_r);
      m_r    <= (M_W'(d_r) << 9) - (M_W'(d_r) << 3) - (M_W'(d_r) << 2);
    end
    // numerator p*251*2^15 + 250*d, divisor 500*d, quotient below 2^15
    if (cmd.prep2) begin
      rem_r <= (DV_W'(p251_r) << 15) + DV_W'(m_r >> 1);
      msh_r <= DV_W'(m_r) << (DIV_STEPS - 1);
      q_r   <= '0;
    end
    if (cmd.div) begin
      if (rem_r >= msh_r) begin
        rem_r <= rem_r - msh_r;
        q_r   <= {q_r[GAIN_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[GAIN_W-2:0], 1'b0};
      end
      msh_r <= msh_r >> 1;
    end
    if (cmd.fin) begin
      gain_r <= ok_r ? q_r : '0;
      err_r  <= !ok_r;
    end
  end

endmodule

### src/adc_gain_calibrator_core.sv
// ADC gain calibrator.
// Input channel: an item (in_sample, in_last) is taken at a rising edge where
// start is high and busy is low. Items without in_last are classified and
// summed in the cycle they are taken, so they stream at one per cycle.
// The item with in_last ends a calibration set: busy rises and the block
// forms the cross products, checks the gain range and runs a restoring
// divider that yields one quotient bit per cycle. out_valid pulses for one
// cycle once the result is latched after the divider (after the range check
// on an error), with out_gain in unsigned Q0.15 and out_error. busy drops in
// the cycle out_valid rises, so the next set can start at once.
// The result cannot be held off: it must be taken in its strobe cycle.
// Configuration: cfg_index/cfg_data written when cfg_valid is high; cfg_ready
// is always high. Write only while the block is idle.
// Reset (rst_n low, synchronous) restores mid_level 128, band 60,
// target_span 160 and clears both sums and counts.
module adc_gain_calibrator_core
  import agc_pkg::*;
#(
  parameter int MAX_SAMPLES = 16384
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [SAMPLE_W-1:0]   in_sample,
  input  logic                  in_last,
  output logic                  out_valid,
  output logic [GAIN_W-1:0]     out_gain,
  output logic                  out_error,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data
);

  agc_cmd_t cmd;
  agc_sts_t sts;

  assign cfg_ready = 1'b1;

  agc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_last   (in_last),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  agc_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_sample (in_sample),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_gain  (out_gain),
    .out_error (out_error)
  );

endmodule
